[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk, with an empty body for
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check on every rising edge of clk while out of reset.
`define ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[rtl/core/hfe_pkg.sv]
// ----------------------------------------------------------------------------
// hfe_pkg
// Shared types, constants and the CRC-16 byte update of the frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hfe_pkg;

	localparam logic [7:0]  FLAG_BYTE = 8'h7E;
	localparam logic [7:0]  ESC_BYTE  = 8'h7D;
	localparam logic [7:0]  ESC_FLAG  = 8'h5E;
	localparam logic [7:0]  ESC_ESC   = 8'h5D;
	localparam logic [15:0] CRC_POLY  = 16'h8408;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;

	// default depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// one accepted item, classified and ready for the back end
	typedef struct packed {
		logic [15:0] fcs;    // complemented CRC, valid when last is set
		logic [7:0]  data;
		logic        last;
		logic        mode;   // frame uses flags and escaping
		logic        open;   // emit an opening flag first
	} hfe_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} hfe_q_status_t;

	typedef enum logic [2:0] {
		BK_FIRST,
		BK_OPEN,
		BK_DATA,
		BK_FCS_LO,
		BK_FCS_HI,
		BK_CLOSE
	} hfe_bk_state_t;

	// reflected CRC-16, one byte, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/core/hfe_front.sv]
// ----------------------------------------------------------------------------
// hfe_front
// Accepts payload items, tracks frame state and CRC, pushes one command each.
// ----------------------------------------------------------------------------
`default_nettype none

module hfe_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,
	input  wire logic                  s_tlast,
	input  wire logic                  s_tuser,
	input  wire hfe_pkg::hfe_q_status_t q_stat,
	output logic                       q_push,
	output hfe_pkg::hfe_entry_t        q_entry
);

	logic [15:0] crc_q;
	logic        inside_q;
	logic        mode_q;
	logic        mode_eff;
	logic [15:0] crc_start;
	logic [15:0] crc_next;

	assign s_tready  = !q_stat.full;
	assign q_push    = s_tvalid && s_tready;

	// a new frame samples the mode and restarts the CRC
	assign mode_eff  = inside_q ? mode_q : s_tuser;
	assign crc_start = inside_q ? crc_q : hfe_pkg::CRC_INIT;
	assign crc_next  = hfe_pkg::crc_byte(crc_start, s_tdata);

	always_comb begin
		q_entry.fcs  = ~crc_next;
		q_entry.data = s_tdata;
		q_entry.last = s_tlast;
		q_entry.mode = mode_eff;
		q_entry.open = !inside_q && s_tuser;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= hfe_pkg::CRC_INIT;
			inside_q <= 1'b0;
			mode_q   <= 1'b0;
		end else if (q_push) begin
			mode_q   <= mode_eff;
			inside_q <= !s_tlast;
			crc_q    <= s_tlast ? hfe_pkg::CRC_INIT : crc_next;
		end
	end

endmodule

`default_nettype wire

[rtl/core/hfe_queue.sv]
// ----------------------------------------------------------------------------
// hfe_queue
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hfe_queue #(
	parameter int QDEPTH = hfe_pkg::QUEUE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire hfe_pkg::hfe_entry_t push_entry,
	input  wire logic                pop,
	output hfe_pkg::hfe_entry_t      head,
	output hfe_pkg::hfe_q_status_t   stat
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	hfe_pkg::hfe_entry_t mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CW'(QDEPTH));
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ASSERT_RST(a_q_no_overflow, !(push && stat.full), "queue push while full")
	`ASSERT_RST(a_q_no_underflow, !(pop && stat.empty), "queue pop while empty")
	`ASSERT_RST(a_q_cnt_bound, cnt_q <= CW'(QDEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

[rtl/core/hfe_back.sv]
// ----------------------------------------------------------------------------
// hfe_back
// Expands each command into flags, escaped bytes and FCS, one byte a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hfe_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire hfe_pkg::hfe_entry_t    head,
	input  wire hfe_pkg::hfe_q_status_t q_stat,
	output logic                        pop,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [7:0]                  m_tdata,
	output logic                        m_tlast
);

	hfe_pkg::hfe_bk_state_t st_q, st_d, cur, nxt;
	logic       esc_q, esc_d;
	logic       step;
	logic       coded;
	logic [7:0] src;
	logic       hold_esc;
	logic       done;
	logic [7:0] byte_d;
	logic       last_d;

	// advance whenever a command waits and the output register is free
	assign step = !q_stat.empty && (!m_tvalid || m_tready);

	// next state
	always_comb begin
		cur = (st_q == hfe_pkg::BK_FIRST) ?
			(head.open ? hfe_pkg::BK_OPEN : hfe_pkg::BK_DATA) : st_q;
		coded = 1'b0;
		src   = head.data;
		nxt   = hfe_pkg::BK_FIRST;
		unique case (cur)
			hfe_pkg::BK_OPEN: begin
				nxt = hfe_pkg::BK_DATA;
			end
			hfe_pkg::BK_DATA: begin
				coded = 1'b1;
				src   = head.data;
				nxt   = head.last ? hfe_pkg::BK_FCS_LO : hfe_pkg::BK_FIRST;
			end
			hfe_pkg::BK_FCS_LO: begin
				coded = 1'b1;
				src   = head.fcs[7:0];
				nxt   = hfe_pkg::BK_FCS_HI;
			end
			hfe_pkg::BK_FCS_HI: begin
				coded = 1'b1;
				src   = head.fcs[15:8];
				nxt   = head.mode ? hfe_pkg::BK_CLOSE : hfe_pkg::BK_FIRST;
			end
			default: begin
				nxt = hfe_pkg::BK_FIRST;
			end
		endcase
		hold_esc = coded && head.mode && !esc_q &&
			(src == hfe_pkg::FLAG_BYTE || src == hfe_pkg::ESC_BYTE);
		done  = !hold_esc && (nxt == hfe_pkg::BK_FIRST);
		st_d  = hold_esc ? cur : nxt;
		esc_d = hold_esc;
		pop   = step && done;
	end

	// outputs
	always_comb begin
		if (!coded) begin
			byte_d = hfe_pkg::FLAG_BYTE;
		end else if (hold_esc) begin
			byte_d = hfe_pkg::ESC_BYTE;
		end else if (esc_q) begin
			byte_d = (src == hfe_pkg::FLAG_BYTE) ? hfe_pkg::ESC_FLAG : hfe_pkg::ESC_ESC;
		end else begin
			byte_d = src;
		end
		last_d = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= hfe_pkg::BK_FIRST;
			esc_q    <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (step) begin
				st_q  <= st_d;
				esc_q <= esc_d;
			end
			if (step) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			m_tdata <= byte_d;
			m_tlast <= last_d;
		end
	end

	`ASSERT_RST(a_bk_esc_phase, !esc_q || st_q == hfe_pkg::BK_DATA || st_q == hfe_pkg::BK_FCS_LO || st_q == hfe_pkg::BK_FCS_HI, "escape pending outside a coded byte")
	`ASSERT_RST(a_bk_esc_second, (step && esc_q) |=> (m_tdata == hfe_pkg::ESC_FLAG || m_tdata == hfe_pkg::ESC_ESC), "bad second escape byte")
	`ASSERT_RST(a_bk_pop_last, (step && hold_esc) |-> !pop, "command dropped mid escape")

endmodule

`default_nettype wire

[rtl/core/hdlc_frame_encoder_crc16.sv]
// ----------------------------------------------------------------------------
// hdlc_frame_encoder_crc16
// Async-HDLC style byte framer with CRC-16/X.25 frame check sequence.
// ----------------------------------------------------------------------------
// Payload bytes enter one item at a time; the item marked last ends the frame
// and the complemented CRC-16 (reflected, poly 0x8408, init 0xFFFF) follows it,
// low byte first. The framing mode is taken from tuser on a frame's first item
// only. In framed mode the frame opens and closes with 0x7E, and every payload
// and FCS byte equal to 0x7E or 0x7D goes out as 7D 5E or 7D 5D. In plain mode
// bytes and FCS go out unchanged. m_tlast marks the final byte that one input
// item causes. The front end accepts an item (CRC update and classification)
// and pushes a command into a queue of QDEPTH entries; the back end drains it
// at one output byte per cycle while m_tready allows. An item yields 1 output
// byte when ordinary, 2 when it is escaped, up to 8 for a one-byte framed
// frame with both FCS bytes escaped. The sustained rate is set by that single
// output byte lane; input ready drops only when the queue is full. No reset
// pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlc_frame_encoder_crc16 #(
	parameter int QDEPTH = hfe_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic       s_tlast,   // last_byte
	input  wire logic       s_tuser,   // [0] framed_mode
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic            m_tlast    // run_last
);

	hfe_pkg::hfe_entry_t    push_entry;
	hfe_pkg::hfe_entry_t    head;
	hfe_pkg::hfe_q_status_t q_stat;
	logic                   push;
	logic                   pop;

	// front: accept items, run the CRC, classify into commands
	hfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.q_push   (push),
		.q_entry  (push_entry)
	);

	// hold commands so front and back stall independently
	hfe_queue #(
		.QDEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	// back: emit flags, escapes and FCS through the output register
	hfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the HDLC frame encoder with CRC-16/X.25.
// ----------------------------------------------------------------------------
// Payload bytes go in on the slave stream. Each accepted item is run through
// a local encoder model that keeps its own CRC, frame and mode state. The
// model queues the line bytes that the item should cause, and a monitor
// compares every output byte against the oldest queued one. Directed frames
// come first: plain and framed, one-byte frames, mode flips inside a frame,
// and frames whose FCS bytes need escaping. Random frames follow, with bursts
// of idle on both streams, and the run ends on a stretch with no idling.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int     CLK_HALF      = 5;
	localparam int     RST_CYCLES    = 5;
	localparam int     RANDOM_ITEMS  = 230;
	localparam int     QUIET_ITEMS   = 60;
	localparam int     SETTLE_CYCLES = 32;
	localparam longint TIMEOUT_NS    = 5_000_000;

	// one byte on the serial line, with the end-of-run marker for its item
	typedef struct {
		logic [7:0] value;
		logic       run_end;
	} line_byte_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] data_byte
	logic       s_tlast;   // last_byte
	logic       s_tuser;   // [0] framed_mode
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [7:0] out_byte
	logic       m_tlast;   // run_last

	// encoder model state
	logic [15:0] fcs_acc;
	logic        in_frame;
	logic        framed;

	line_byte_t  line_q[$];   // line bytes still owed by the block
	int          errors;
	bit          tx_gaps;     // sender may insert idle bursts
	bit          rx_stalls;   // receiver may insert stall bursts
	int          rx_hold;

	hdlc_frame_encoder_crc16 uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Encoder model
	// ------------------------------------------------------------------

	// bit-serial form of the reflected CRC: feed data LSB first into bit 0
	function automatic logic [15:0] fcs_advance(logic [15:0] acc, logic [7:0] b);
		for (int i = 0; i < 8; i++) begin
			acc = (acc[0] ^ b[i]) ? ((acc >> 1) ^ hfe_pkg::CRC_POLY) : (acc >> 1);
		end
		return acc;
	endfunction

	function automatic void put_line(logic [7:0] v);
		line_byte_t e;
		e.value   = v;
		e.run_end = 1'b0;
		line_q.push_back(e);
	endfunction

	// byte-stuff payload and FCS bytes that collide with flag or escape
	function automatic void put_stuffed(logic [7:0] v);
		if (framed && (v == hfe_pkg::FLAG_BYTE || v == hfe_pkg::ESC_BYTE)) begin
			put_line(hfe_pkg::ESC_BYTE);
			put_line(v == hfe_pkg::FLAG_BYTE ? hfe_pkg::ESC_FLAG : hfe_pkg::ESC_ESC);
		end else begin
			put_line(v);
		end
	endfunction

	// queue the line bytes caused by one accepted payload item
	function automatic void encode_item(logic [7:0] b, logic fin, logic mode);
		logic [15:0] fcs;
		line_byte_t  tail;
		if (!in_frame) begin
			// mode is latched on the first byte only
			framed   = mode;
			fcs_acc  = hfe_pkg::CRC_INIT;
			in_frame = 1'b1;
			if (framed)
				put_line(hfe_pkg::FLAG_BYTE);
		end
		put_stuffed(b);
		fcs_acc = fcs_advance(fcs_acc, b);
		if (fin) begin
			fcs = ~fcs_acc;
			put_stuffed(fcs[7:0]);
			put_stuffed(fcs[15:8]);
			if (framed)
				put_line(hfe_pkg::FLAG_BYTE);
			fcs_acc  = hfe_pkg::CRC_INIT;
			in_frame = 1'b0;
		end
		tail         = line_q.pop_back();
		tail.run_end = 1'b1;
		line_q.push_back(tail);
	endfunction

	// two-byte payload whose FCS equals the target; for a 16-bit message
	// the CRC map is one-to-one, so exactly one payload matches
	function automatic logic [15:0] payload_for_fcs(logic [15:0] target);
		logic [15:0] acc;
		for (int m = 0; m < 65536; m++) begin
			acc = fcs_advance(fcs_advance(hfe_pkg::CRC_INIT, m[7:0]), m[15:8]);
			if (~acc == target)
				return m[15:0];
		end
		return 16'h0000;
	endfunction

	// ------------------------------------------------------------------
	// Stream drivers and monitor
	// ------------------------------------------------------------------

	// receiver: stall in bursts while stalls are enabled
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold  <= rx_hold - 1;
			m_tready <= 1'b0;
		end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
			rx_hold  <= int'($urandom_range(0, 15));
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor: compare each accepted output byte with the oldest expectation
	always @(posedge clk) begin
		line_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (line_q.size() == 0) begin
				errors++;
				$error("unexpected output item: out_byte %02h run_last %0b", m_tdata, m_tlast);
			end else begin
				want = line_q.pop_front();
				if (m_tdata !== want.value) begin
					errors++;
					$error("out_byte: expected %02h, got %02h", want.value, m_tdata);
				end
				if (m_tlast !== want.run_end) begin
					errors++;
					$error("run_last: expected %0b, got %0b", want.run_end, m_tlast);
				end
			end
		end
	end

	// send one payload item; valid stays high afterward unless a gap follows
	task automatic send_byte(input logic [7:0] b, input logic fin, input logic mode);
		int gap;
		gap = (tx_gaps && $urandom_range(0, 4) == 0) ? int'($urandom_range(1, 16)) : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		s_tuser  <= mode;
		do @(posedge clk); while (!s_tready);
		encode_item(b, fin, mode);
	endtask

	// drop valid and hold off until every owed byte has come out
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (line_q.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// plain mode: no flags, no stuffing even for 7E/7D, mode flip ignored
	task automatic test_plain_frames();
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hFF, 1'b1, 1'b0);
		send_byte(8'h7E, 1'b0, 1'b0);
		send_byte(8'h7D, 1'b0, 1'b1);
		send_byte(8'hA5, 1'b1, 1'b1);
	endtask

	// framed mode: flags, stuffing, one-byte frames, mode flip ignored
	task automatic test_framed_frames();
		send_byte(8'h7E, 1'b1, 1'b1);
		send_byte(8'h7D, 1'b1, 1'b1);
		send_byte(8'h00, 1'b0, 1'b1);
		send_byte(8'h7E, 1'b0, 1'b0);
		send_byte(8'h7D, 1'b0, 1'b1);
		send_byte(8'hFF, 1'b1, 1'b0);
	endtask

	// frames whose FCS bytes are themselves flag or escape values
	task automatic test_escaped_fcs();
		logic [15:0] p;
		p = payload_for_fcs({hfe_pkg::FLAG_BYTE, hfe_pkg::FLAG_BYTE});
		send_byte(p[7:0], 1'b0, 1'b1);
		send_byte(p[15:8], 1'b1, 1'b0);
		p = payload_for_fcs({hfe_pkg::ESC_BYTE, hfe_pkg::ESC_BYTE});
		send_byte(p[7:0], 1'b0, 1'b1);
		send_byte(p[15:8], 1'b1, 1'b1);
		p = payload_for_fcs({hfe_pkg::FLAG_BYTE, hfe_pkg::ESC_BYTE});
		send_byte(p[7:0], 1'b0, 1'b1);
		send_byte(p[15:8], 1'b1, 1'b1);
		// same kind of FCS in plain mode goes out unstuffed
		p = payload_for_fcs({hfe_pkg::ESC_BYTE, hfe_pkg::FLAG_BYTE});
		send_byte(p[7:0], 1'b0, 1'b0);
		send_byte(p[15:8], 1'b1, 1'b0);
	endtask

	// whole random frames until at least n_items are sent
	task automatic test_random_frames(input int n_items, input bit allow_idle);
		int         sent;
		int         len;
		logic [7:0] b;
		logic       mode;
		sent = 0;
		while (sent < n_items) begin
			// idle settings change per frame, leaving some frames at full rate
			tx_gaps   = allow_idle && ($urandom_range(0, 3) != 0);
			rx_stalls = allow_idle && ($urandom_range(0, 3) != 0);
			len  = ($urandom_range(0, 7) == 0) ? int'($urandom_range(9, 24)) :
				int'($urandom_range(1, 8));
			mode = 1'($urandom_range(0, 1));
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 7))
					0:       b = hfe_pkg::FLAG_BYTE;
					1:       b = hfe_pkg::ESC_BYTE;
					default: b = 8'($urandom_range(0, 255));
				endcase
				// later bytes carry a random mode bit, which must not matter
				send_byte(b, i == len - 1, (i == 0) ? mode : 1'($urandom_range(0, 1)));
				sent++;
			end
		end
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = 8'h00;
		s_tlast   = 1'b0;
		s_tuser   = 1'b0;
		m_tready  = 1'b0;
		rx_hold   = 0;
		tx_gaps   = 1'b0;
		rx_stalls = 1'b0;
		errors    = 0;
		fcs_acc   = hfe_pkg::CRC_INIT;
		in_frame  = 1'b0;
		framed    = 1'b0;

		repeat (RST_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		test_plain_frames();
		test_framed_frames();
		test_escaped_fcs();
		wait_drained();

		test_random_frames(RANDOM_ITEMS, 1'b1);
		wait_drained();
		// closing stretch at full rate on both sides
		test_random_frames(QUIET_ITEMS, 1'b0);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#TIMEOUT_NS;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
